// ===== rtl/core/tcgc_pkg.sv =====
// ----------------------------------------------------------------------------
// tcgc_pkg
// Shared constants, types and helpers for the text console grid cursor.
// ----------------------------------------------------------------------------
package tcgc_pkg;

    localparam int MAX_COLS = 128;
    localparam int MAX_ROWS = 64;

    localparam int ROW_W  = $clog2(MAX_ROWS);
    localparam int COL_W  = $clog2(MAX_COLS);
    localparam int CCNT_W = $clog2(MAX_COLS + 1);
    localparam int RCNT_W = $clog2(MAX_ROWS + 1);
    localparam int ADDR_W = $clog2(MAX_ROWS * MAX_COLS);
    localparam int CHAR_W = 8;

    localparam int COLS_CFG_W = 8;
    localparam int ROWS_CFG_W = 7;
    localparam int CFG_DATA_W = 8;
    localparam int CFG_IDX_W  = 1;

    localparam logic [COLS_CFG_W-1:0] COLS_RESET = COLS_CFG_W'(80);
    localparam logic [ROWS_CFG_W-1:0] ROWS_RESET = ROWS_CFG_W'(25);

    localparam logic [CFG_IDX_W-1:0] REG_COLS = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_ROWS = CFG_IDX_W'(1);

    localparam logic [1:0] OP_PUT   = 2'd0;
    localparam logic [1:0] OP_BS    = 2'd1;
    localparam logic [1:0] OP_CLEAR = 2'd2;

    localparam logic [CHAR_W-1:0] CH_NEWLINE = 8'd10;
    localparam logic [CHAR_W-1:0] CH_RETURN  = 8'd13;
    localparam logic [CHAR_W-1:0] CH_BLANK   = 8'd0;

    typedef struct packed {
        logic                re;
        logic [ADDR_W-1:0]   raddr;
        logic                we;
        logic [ADDR_W-1:0]   waddr;
        logic [CHAR_W-1:0]   wdata;
    } mem_req_t;

    typedef struct packed {
        logic [ROW_W-1:0]    cell_row;
        logic [COL_W-1:0]    cell_col;
        logic [CHAR_W-1:0]   cell_char;
        logic                cell_written;
        logic                cell_changed;
        logic                scrolled;
        logic                cleared;
        logic [ROW_W-1:0]    cursor_row;
        logic [COL_W-1:0]    cursor_col;
    } res_t;

    // (base + off) mod MAX_ROWS, off no larger than MAX_ROWS
    function automatic logic [ROW_W-1:0] phys_row(input logic [ROW_W-1:0]  base,
                                                  input logic [RCNT_W-1:0] off);
        logic [RCNT_W:0] sum;
        sum = (RCNT_W+1)'(base) + (RCNT_W+1)'(off);
        if (sum >= (RCNT_W+1)'(MAX_ROWS))
        begin
            sum = sum - (RCNT_W+1)'(MAX_ROWS);
        end
        return sum[ROW_W-1:0];
    endfunction

    function automatic logic [ADDR_W-1:0] cell_addr(input logic [ROW_W-1:0] phys,
                                                    input logic [COL_W-1:0] col);
        logic [ADDR_W-1:0] a;
        a = ADDR_W'(phys) * ADDR_W'(MAX_COLS);
        a = a + ADDR_W'(col);
        return a;
    endfunction

endpackage

// ===== rtl/core/tcgc_cell_store.sv =====
// ----------------------------------------------------------------------------
// tcgc_cell_store
// Character cell memory: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module tcgc_cell_store
(
    input  logic                              clk,
    input  tcgc_pkg::mem_req_t                req,
    output logic [tcgc_pkg::CHAR_W-1:0]       rd_data
);

    logic [tcgc_pkg::CHAR_W-1:0] mem [tcgc_pkg::MAX_ROWS*tcgc_pkg::MAX_COLS];
    logic [tcgc_pkg::CHAR_W-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (req.we)
        begin
            mem[req.waddr] <= req.wdata;
        end
        if (req.re)
        begin
            rd_data_reg <= mem[req.raddr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== rtl/core/text_console_grid_cursor.sv =====
// ----------------------------------------------------------------------------
// text_console_grid_cursor
// Text console grid engine: put character, backspace and clear commands on a
// character cell store with cursor tracking and row-ring scrolling.
// ----------------------------------------------------------------------------
// One command is in flight at a time. A printable put or a backspace reads
// its cell on acceptance, then compares and writes it back the next cycle.
// A scroll also writes a blank to each column of the physical row being
// blanked (128), one cell a cycle, and clear sweeps the whole store, one
// cell a cycle. After reset the store is blanked before the first command
// is taken; configuration writes are accepted at any time.
module text_console_grid_cursor
(
    input  logic                                clk,
    input  logic                                rst_n,

    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [tcgc_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [tcgc_pkg::CFG_DATA_W-1:0]     cfg_data,

    input  logic                                cmd_valid,
    output logic                                cmd_stall,
    input  logic [1:0]                          opcode,
    input  logic [tcgc_pkg::CHAR_W-1:0]         char_code,

    output logic                                res_valid,
    input  logic                                res_stall,
    output logic [tcgc_pkg::ROW_W-1:0]          cell_row,
    output logic [tcgc_pkg::COL_W-1:0]          cell_col,
    output logic [tcgc_pkg::CHAR_W-1:0]         cell_char,
    output logic                                cell_written,
    output logic                                cell_changed,
    output logic                                scrolled,
    output logic                                cleared,
    output logic [tcgc_pkg::ROW_W-1:0]          cursor_row,
    output logic [tcgc_pkg::COL_W-1:0]          cursor_col
);

    typedef enum logic [2:0] {
        S_INIT,
        S_IDLE,
        S_RMW,
        S_SCROLL,
        S_CLEAR,
        S_OUT
    } state_t;

    localparam logic [tcgc_pkg::ADDR_W-1:0] LAST_ADDR =
        tcgc_pkg::ADDR_W'(tcgc_pkg::MAX_ROWS * tcgc_pkg::MAX_COLS - 1);
    localparam logic [tcgc_pkg::ADDR_W-1:0] LAST_COL_SWEEP =
        tcgc_pkg::ADDR_W'(tcgc_pkg::MAX_COLS - 1);

    state_t                              state_reg, state_next;
    logic [tcgc_pkg::COLS_CFG_W-1:0]     cols_reg, cols_next;
    logic [tcgc_pkg::ROWS_CFG_W-1:0]     rows_reg, rows_next;
    logic [tcgc_pkg::ROW_W-1:0]          crow_reg, crow_next;
    logic [tcgc_pkg::COL_W-1:0]          ccol_reg, ccol_next;
    logic [tcgc_pkg::ROW_W-1:0]          row_base_reg, row_base_next;
    logic [tcgc_pkg::ADDR_W-1:0]         sweep_reg, sweep_next;
    logic [tcgc_pkg::ADDR_W-1:0]         scroll_base_reg, scroll_base_next;
    logic [tcgc_pkg::ADDR_W-1:0]         addr_reg, addr_next;
    logic [tcgc_pkg::CHAR_W-1:0]         wdata_reg, wdata_next;
    logic                                is_put_reg, is_put_next;
    tcgc_pkg::res_t                      res_reg, res_next;
    tcgc_pkg::res_t                      out_reg, out_next;
    logic                                out_valid_reg, out_valid_next;

    tcgc_pkg::mem_req_t                  mem_req;
    logic [tcgc_pkg::CHAR_W-1:0]         rd_data;

    logic [tcgc_pkg::CCNT_W-1:0]         cols_eff;
    logic [tcgc_pkg::RCNT_W-1:0]         rows_eff;
    logic [tcgc_pkg::ROW_W-1:0]          last_row;
    logic [tcgc_pkg::COL_W-1:0]          last_col;
    logic [tcgc_pkg::ROW_W-1:0]          sat_row, bs_row;
    logic [tcgc_pkg::COL_W-1:0]          sat_col, bs_col;
    logic [tcgc_pkg::ROW_W-1:0]          rb_inc;
    logic [tcgc_pkg::ADDR_W-1:0]         scroll_addr;
    logic                                cmd_acc;
    logic                                out_free;

    tcgc_cell_store u_store
    (
        .clk     (clk),
        .req     (mem_req),
        .rd_data (rd_data)
    );

    assign cmd_stall = (state_reg != S_IDLE);
    assign cmd_acc   = cmd_valid && !cmd_stall;
    assign out_free  = !out_valid_reg || !res_stall;
    assign cfg_ready = 1'b1;

    always_comb
    begin
        if (cols_reg == '0)
            cols_eff = tcgc_pkg::CCNT_W'(1);
        else if (32'(cols_reg) > tcgc_pkg::MAX_COLS)
            cols_eff = tcgc_pkg::CCNT_W'(tcgc_pkg::MAX_COLS);
        else
            cols_eff = tcgc_pkg::CCNT_W'(cols_reg);

        if (rows_reg == '0)
            rows_eff = tcgc_pkg::RCNT_W'(1);
        else if (32'(rows_reg) > tcgc_pkg::MAX_ROWS)
            rows_eff = tcgc_pkg::RCNT_W'(tcgc_pkg::MAX_ROWS);
        else
            rows_eff = tcgc_pkg::RCNT_W'(rows_reg);

        last_row = tcgc_pkg::ROW_W'(rows_eff - 1'b1);
        last_col = tcgc_pkg::COL_W'(cols_eff - 1'b1);

        sat_row = (tcgc_pkg::RCNT_W'(crow_reg) >= rows_eff) ? last_row : crow_reg;
        sat_col = (tcgc_pkg::CCNT_W'(ccol_reg) >= cols_eff) ? last_col : ccol_reg;

        bs_row = sat_row;
        bs_col = sat_col;
        if (sat_col != '0)
        begin
            bs_col = sat_col - 1'b1;
        end
        else if (sat_row != '0)
        begin
            bs_row = sat_row - 1'b1;
            bs_col = last_col;
        end

        rb_inc = (row_base_reg == tcgc_pkg::ROW_W'(tcgc_pkg::MAX_ROWS - 1)) ?
                 '0 : row_base_reg + 1'b1;
        // new bottom row after a scroll: (old base + rows) mod MAX_ROWS
        scroll_addr = tcgc_pkg::cell_addr(tcgc_pkg::phys_row(row_base_reg, rows_eff), '0);
    end

    always_comb
    begin
        state_next       = state_reg;
        cols_next        = cols_reg;
        rows_next        = rows_reg;
        crow_next        = crow_reg;
        ccol_next        = ccol_reg;
        row_base_next    = row_base_reg;
        sweep_next       = sweep_reg;
        scroll_base_next = scroll_base_reg;
        addr_next        = addr_reg;
        wdata_next       = wdata_reg;
        is_put_next      = is_put_reg;
        res_next         = res_reg;
        out_next         = out_reg;
        out_valid_next   = out_valid_reg && res_stall;
        mem_req          = '0;

        if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                tcgc_pkg::REG_COLS: cols_next = cfg_data;
                tcgc_pkg::REG_ROWS: rows_next = cfg_data[tcgc_pkg::ROWS_CFG_W-1:0];
                default: ;
            endcase
        end

        case (state_reg)
            S_INIT:
            begin
                mem_req.we    = 1'b1;
                mem_req.waddr = sweep_reg;
                mem_req.wdata = tcgc_pkg::CH_BLANK;
                sweep_next    = sweep_reg + 1'b1;
                if (sweep_reg == LAST_ADDR)
                begin
                    state_next = S_IDLE;
                end
            end

            S_IDLE:
            begin
                if (cmd_acc)
                begin
                    res_next            = '0;
                    res_next.cursor_row = sat_row;
                    res_next.cursor_col = sat_col;
                    crow_next           = sat_row;
                    ccol_next           = sat_col;
                    state_next          = S_OUT;
                    case (opcode)
                        tcgc_pkg::OP_PUT:
                        begin
                            if (char_code == tcgc_pkg::CH_NEWLINE)
                            begin
                                ccol_next           = '0;
                                res_next.cursor_col = '0;
                                if (sat_row == last_row)
                                begin
                                    res_next.scrolled = 1'b1;
                                    row_base_next     = rb_inc;
                                    scroll_base_next  = scroll_addr;
                                    sweep_next        = '0;
                                    state_next        = S_SCROLL;
                                end
                                else
                                begin
                                    crow_next           = sat_row + 1'b1;
                                    res_next.cursor_row = sat_row + 1'b1;
                                end
                            end
                            else if (char_code == tcgc_pkg::CH_RETURN)
                            begin
                                ccol_next           = '0;
                                res_next.cursor_col = '0;
                            end
                            else
                            begin
                                mem_req.re    = 1'b1;
                                mem_req.raddr = tcgc_pkg::cell_addr(
                                    tcgc_pkg::phys_row(row_base_reg,
                                                       tcgc_pkg::RCNT_W'(sat_row)),
                                    sat_col);
                                addr_next     = mem_req.raddr;
                                wdata_next    = char_code;
                                is_put_next   = 1'b1;
                                state_next    = S_RMW;
                            end
                        end

                        tcgc_pkg::OP_BS:
                        begin
                            crow_next     = bs_row;
                            ccol_next     = bs_col;
                            mem_req.re    = 1'b1;
                            mem_req.raddr = tcgc_pkg::cell_addr(
                                tcgc_pkg::phys_row(row_base_reg,
                                                   tcgc_pkg::RCNT_W'(bs_row)),
                                bs_col);
                            addr_next     = mem_req.raddr;
                            wdata_next    = tcgc_pkg::CH_BLANK;
                            is_put_next   = 1'b0;
                            state_next    = S_RMW;
                        end

                        tcgc_pkg::OP_CLEAR:
                        begin
                            crow_next           = '0;
                            ccol_next           = '0;
                            row_base_next       = '0;
                            res_next.cursor_row = '0;
                            res_next.cursor_col = '0;
                            res_next.cleared    = 1'b1;
                            sweep_next          = '0;
                            state_next          = S_CLEAR;
                        end

                        default: ;
                    endcase
                end
            end

            S_RMW:
            begin
                mem_req.we            = 1'b1;
                mem_req.waddr         = addr_reg;
                mem_req.wdata         = wdata_reg;
                res_next              = '0;
                res_next.cell_row     = crow_reg;
                res_next.cell_col     = ccol_reg;
                res_next.cell_char    = wdata_reg;
                res_next.cell_written = 1'b1;
                res_next.cell_changed = (rd_data != wdata_reg);
                res_next.cursor_row   = crow_reg;
                res_next.cursor_col   = ccol_reg;
                state_next            = S_OUT;
                if (is_put_reg)
                begin
                    if (ccol_reg == last_col)
                    begin
                        ccol_next           = '0;
                        res_next.cursor_col = '0;
                        if (crow_reg == last_row)
                        begin
                            res_next.scrolled = 1'b1;
                            row_base_next     = rb_inc;
                            scroll_base_next  = scroll_addr;
                            sweep_next        = '0;
                            state_next        = S_SCROLL;
                        end
                        else
                        begin
                            crow_next           = crow_reg + 1'b1;
                            res_next.cursor_row = crow_reg + 1'b1;
                        end
                    end
                    else
                    begin
                        ccol_next           = ccol_reg + 1'b1;
                        res_next.cursor_col = ccol_reg + 1'b1;
                    end
                end
                if (state_next == S_OUT && out_free)
                begin
                    out_next       = res_next;
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end

            S_SCROLL:
            begin
                mem_req.we    = 1'b1;
                mem_req.waddr = scroll_base_reg + sweep_reg;
                mem_req.wdata = tcgc_pkg::CH_BLANK;
                sweep_next    = sweep_reg + 1'b1;
                if (sweep_reg == LAST_COL_SWEEP)
                begin
                    state_next = S_OUT;
                end
            end

            S_CLEAR:
            begin
                mem_req.we    = 1'b1;
                mem_req.waddr = sweep_reg;
                mem_req.wdata = tcgc_pkg::CH_BLANK;
                sweep_next    = sweep_reg + 1'b1;
                if (sweep_reg == LAST_ADDR)
                begin
                    state_next = S_OUT;
                end
            end

            S_OUT:
            begin
                if (out_free)
                begin
                    out_next       = res_reg;
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_INIT;
            cols_reg        <= tcgc_pkg::COLS_RESET;
            rows_reg        <= tcgc_pkg::ROWS_RESET;
            crow_reg        <= '0;
            ccol_reg        <= '0;
            row_base_reg    <= '0;
            sweep_reg       <= '0;
            out_valid_reg   <= 1'b0;
            out_reg         <= '0;
        end
        else
        begin
            state_reg       <= state_next;
            cols_reg        <= cols_next;
            rows_reg        <= rows_next;
            crow_reg        <= crow_next;
            ccol_reg        <= ccol_next;
            row_base_reg    <= row_base_next;
            sweep_reg       <= sweep_next;
            out_valid_reg   <= out_valid_next;
            out_reg         <= out_next;
        end
    end

    always_ff @(posedge clk)
    begin
        scroll_base_reg <= scroll_base_next;
        addr_reg        <= addr_next;
        wdata_reg       <= wdata_next;
        is_put_reg      <= is_put_next;
        res_reg         <= res_next;
    end

    assign res_valid    = out_valid_reg;
    assign cell_row     = out_reg.cell_row;
    assign cell_col     = out_reg.cell_col;
    assign cell_char    = out_reg.cell_char;
    assign cell_written = out_reg.cell_written;
    assign cell_changed = out_reg.cell_changed;
    assign scrolled     = out_reg.scrolled;
    assign cleared      = out_reg.cleared;
    assign cursor_row   = out_reg.cursor_row;
    assign cursor_col   = out_reg.cursor_col;

    a_idle_no_write: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_IDLE) |-> !mem_req.we)
        else $error("cell store written while idle");

    a_read_then_rmw: assert property (@(posedge clk) disable iff (!rst_n)
        mem_req.re |=> (state_reg == S_RMW))
        else $error("cell read not followed by write-back");

    a_blank_result: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid && !out_reg.cell_written) |->
        (out_reg.cell_char == '0 && !out_reg.cell_changed &&
         out_reg.cell_row == '0 && out_reg.cell_col == '0))
        else $error("cell fields set on an item without a write");

    a_scroll_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_SCROLL) |-> (sweep_reg <= LAST_COL_SWEEP))
        else $error("scroll sweep ran past the row");

endmodule
